// File: rtl/aeskd_pkg.sv
package aeskd_pkg;

  localparam int NumRounds = 10;
  localparam int NumStages = 2 * NumRounds;

  typedef enum logic [1:0] {
    FUNC_G3_LEFT = 2'd0,
    FUNC_G3_PROC = 2'd1,
    FUNC_G3_RIGHT = 2'd2,
    FUNC_CMAC = 2'd3
  } func_t;

  localparam logic [127:0] G3_SEED = 128'h7B103C5DCB08C4E51A27B01799053BD9;
  localparam logic [7:0] CMAC_RB = 8'h87;
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef struct packed {
    logic [1:0]   func;
    logic [127:0] key;
    logic [127:0] rk;
    logic [127:0] st;
    logic [127:0] data;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w);
    return {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  // rk[r-1] -> rk[r]
  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] n0, n1, n2, n3;
    n0 = k[127:96] ^ sub_rot(k[31:0]) ^ {rcon(r), 24'h0};
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // rk[r] -> rk[r-1]
  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [3:0] r);
    logic [31:0] p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    p0 = k[127:96] ^ sub_rot(p3) ^ {rcon(r), 24'h0};
    return {p0, p1, p2, p3};
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[c*4+r] = SBOX[s[127-8*(((c+r)%4)*4+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4]   = t[c*4]   ^ all ^ xt(t[c*4]   ^ t[c*4+1]);
      m[c*4+1] = t[c*4+1] ^ all ^ xt(t[c*4+1] ^ t[c*4+2]);
      m[c*4+2] = t[c*4+2] ^ all ^ xt(t[c*4+2] ^ t[c*4+3]);
      m[c*4+3] = t[c*4+3] ^ all ^ xt(t[c*4+3] ^ t[c*4]);
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    end
    return o;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[((c+r)%4)*4+r] = INV_SBOX[s[127-8*(c*4+r) -: 8]];
      end
    end
    for (int i = 0; i < 16; i++) begin
      t[i] = t[i] ^ rk[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        x2[r] = xt(t[c*4+r]);
        x4[r] = xt(x2[r]);
        x8[r] = xt(x4[r]);
      end
      // 14 = 8^4^2, 11 = 8^2^1, 13 = 8^4^1, 9 = 8^1
      a0 = x8[0] ^ x4[0] ^ x2[0];
      a1 = x8[1] ^ x2[1] ^ t[c*4+1];
      a2 = x8[2] ^ x4[2] ^ t[c*4+2];
      a3 = x8[3] ^ t[c*4+3];
      m[c*4] = a0 ^ a1 ^ a2 ^ a3;
      m[c*4+1] = (x8[0] ^ t[c*4]) ^ (x8[1] ^ x4[1] ^ x2[1]) ^ (x8[2] ^ x2[2] ^ t[c*4+2])
               ^ (x8[3] ^ x4[3] ^ t[c*4+3]);
      m[c*4+2] = (x8[0] ^ x4[0] ^ t[c*4]) ^ (x8[1] ^ t[c*4+1]) ^ (x8[2] ^ x4[2] ^ x2[2])
               ^ (x8[3] ^ x2[3] ^ t[c*4+3]);
      m[c*4+3] = (x8[0] ^ x2[0] ^ t[c*4]) ^ (x8[1] ^ x4[1] ^ t[c*4+1]) ^ (x8[2] ^ t[c*4+2])
               ^ (x8[3] ^ x4[3] ^ x2[3]);
    end
    for (int i = 0; i < 16; i++) begin
      o[127-8*i -: 8] = last ? t[i] : m[i];
    end
    return o;
  endfunction

  function automatic logic [127:0] g3_seed(input logic [1:0] f);
    return {G3_SEED[127:8], G3_SEED[7:0] + {6'd0, f}};
  endfunction

endpackage

// File: rtl/aeskd_in_if.sv
interface aeskd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [63:0] data_hi;
  logic [63:0] data_lo;

  modport source (output valid, func, key_hi, key_lo, data_hi, data_lo, input ready);
  modport sink (input valid, func, key_hi, key_lo, data_hi, data_lo, output ready);
endinterface

// File: rtl/aeskd_out_if.sv
interface aeskd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_hi;
  logic [63:0] result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink (input valid, result_hi, result_lo, output ready);
endinterface

// File: rtl/aeskd_stage.sv
// One AES round per stage. Phase 0: key expansion plus AES(key, 0) for CMAC.
// Phase 1: CMAC second encryption, or G3 decryption with the inverse schedule.
module aeskd_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              phase,
  input  logic [3:0]        rnd,
  input  logic              up_valid,
  output logic              up_ready,
  input  aeskd_pkg::stage_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output aeskd_pkg::stage_t dn_data
);
  import aeskd_pkg::*;

  stage_t       nxt;
  logic         cmac;
  logic         last;
  logic [127:0] st0;
  logic [127:0] k1;
  logic [127:0] rk_new;
  logic [127:0] seed;

  assign up_ready = !dn_valid || dn_ready;
  assign cmac = (up_data.func == FUNC_CMAC);
  assign last = (rnd == 4'(NumRounds));
  assign seed = g3_seed(up_data.func);

  always_comb begin
    k1 = {up_data.st[126:0], 1'b0} ^ (up_data.st[127] ? {120'd0, CMAC_RB} : 128'd0);
    st0 = up_data.st;
    nxt = up_data;
    rk_new = up_data.rk;
    if (!phase) begin
      if (rnd == 4'd1) st0 = up_data.key;  // plaintext zero plus rk0
      rk_new = key_fwd(up_data.rk, rnd);
      nxt.rk = rk_new;
      nxt.st = cmac ? enc_round(st0, rk_new, last) : up_data.st;
    end else if (cmac) begin
      if (rnd == 4'd1) begin
        st0 = up_data.data ^ k1 ^ up_data.key;
        rk_new = key_fwd(up_data.key, rnd);
      end else begin
        rk_new = key_fwd(up_data.rk, rnd);
      end
      nxt.rk = rk_new;
      nxt.st = enc_round(st0, rk_new, last);
    end else begin
      if (rnd == 4'd1) st0 = seed ^ up_data.rk;
      rk_new = key_inv(up_data.rk, 4'(NumRounds + 1) - rnd);
      nxt.rk = rk_new;
      nxt.st = dec_round(st0, rk_new, last) ^ (last ? seed : 128'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= nxt;
    end
  end
endmodule

// File: rtl/aes_key_derivation_engine_unit.sv
// AES-128 key derivation engine. Each word in on req gives one word out on rsp.
// func 0..2 returns AES-128-decrypt(key, seed + func) XOR (seed + func), the G3
// left subkey, processing key or right subkey; func 3 returns the one-block
// CMAC AES(key, data XOR K1), with K1 derived from AES(key, 0). A 20-stage
// pipeline of one AES round each (ten rounds of key expansion alongside the
// zero-block encryption, then ten rounds of the main cipher) accepts one word
// every cycle while rsp is ready. Each stage holds its own valid bit and
// registered data, so a stall on rsp fills bubbles upstream first; the last
// stage register drives rsp directly. No state is kept between words and
// reset only clears the valid bits.
module aes_key_derivation_engine_unit (
  input logic       clk,
  input logic       rst,
  aeskd_in_if.sink  req,
  aeskd_out_if.source rsp
);
  import aeskd_pkg::*;

  logic   v   [NumStages+1];
  logic   rdy [NumStages+1];
  stage_t d   [NumStages+1];

  // stage 0 is the input word itself
  assign v[0] = req.valid;
  assign req.ready = rdy[0];
  assign d[0].func = req.func;
  assign d[0].key = {req.key_hi, req.key_lo};
  assign d[0].rk = {req.key_hi, req.key_lo};
  assign d[0].st = '0;
  assign d[0].data = {req.data_hi, req.data_lo};

  for (genvar i = 0; i < NumStages; i++) begin : g_stage
    aeskd_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .phase    (i >= NumRounds),
      .rnd      (4'((i % NumRounds) + 1)),
      .up_valid (v[i]),
      .up_ready (rdy[i]),
      .up_data  (d[i]),
      .dn_valid (v[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_data  (d[i+1])
    );
  end

  assign rdy[NumStages] = rsp.ready;
  assign rsp.valid = v[NumStages];
  assign rsp.result_hi = d[NumStages].st[127:64];
  assign rsp.result_lo = d[NumStages].st[63:0];
endmodule
